>>> sv/lpc_host_memory_cycle_top_defines.svh
// ----------------------------------------------------------------------------
// LPC host memory cycle - assertion macros
// Concurrent assertion forms for the top level.
// ----------------------------------------------------------------------------
`ifndef LPC_HOST_MEMORY_CYCLE_TOP_DEFINES_SVH
`define LPC_HOST_MEMORY_CYCLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define LPC_HMC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define LPC_HMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lpc_hmc_pkg.sv
// ----------------------------------------------------------------------------
// LPC host memory cycle - package
// Phase codes, bus constants and the item structs shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_hmc_pkg;

  // Frame phase codes
  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_START = 5'd1,
    PH_CTYPE = 5'd2,
    PH_ADDR0 = 5'd3,
    PH_ADDR1 = 5'd4,
    PH_ADDR2 = 5'd5,
    PH_ADDR3 = 5'd6,
    PH_ADDR4 = 5'd7,
    PH_ADDR5 = 5'd8,
    PH_ADDR6 = 5'd9,
    PH_ADDR7 = 5'd10,
    PH_WD0   = 5'd11,
    PH_WD1   = 5'd12,
    PH_TAR0  = 5'd13,
    PH_TAR1  = 5'd14,
    PH_SYNC  = 5'd15,
    PH_RD0   = 5'd16,
    PH_RD1   = 5'd17,
    PH_HT0   = 5'd18,
    PH_HT1   = 5'd19
  } lpc_hmc_phase_t;

  // Bus constants
  localparam logic [3:0] CT_READ   = 4'h4;
  localparam logic [3:0] CT_WRITE  = 4'h6;
  localparam logic [3:0] LAD_IDLE  = 4'hF;
  localparam logic [3:0] LAD_SYNC  = 4'h0;
  localparam logic [3:0] LAD_START = 4'h0;
  localparam logic [7:0] RD_ERROR  = 8'hFF;

  // One input tick
  typedef struct packed {
    logic        req_valid;
    logic        req_type;
    logic [31:0] req_addr;
    logic [7:0]  req_wdata;
    logic [3:0]  lad_sample;
  } lpc_hmc_tick_t;

  // One result tick
  typedef struct packed {
    logic [3:0] lad_drive;
    logic       lad_enable;
    logic       lframe_n;
    logic       busy_res;
    logic       frame_done;
    logic       no_response;
    logic [7:0] read_data;
  } lpc_hmc_res_t;

endpackage

`default_nettype wire

>>> sv/lpc_hmc_core.sv
// ----------------------------------------------------------------------------
// LPC host memory cycle - frame sequencer
// Holds the frame phase and request, and works out one tick's bus result.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_hmc_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        step,
  input  lpc_hmc_pkg::lpc_hmc_tick_t tick,
  output lpc_hmc_pkg::lpc_hmc_res_t  res
);
  import lpc_hmc_pkg::*;

  lpc_hmc_phase_t phase_r, phase_nxt, cur;
  logic        is_write_r, is_write_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  wdata_r, wdata_nxt;
  logic [7:0]  rdata_r, rdata_nxt;

  logic        take;
  logic [2:0]  addr_off;
  logic [2:0]  nib_sel;

  // Phase register (control)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  // Request and read data holding registers
  always_ff @(posedge clk) begin
    if (step) begin
      is_write_r <= is_write_nxt;
      addr_r     <= addr_nxt;
      wdata_r    <= wdata_nxt;
      rdata_r    <= rdata_nxt;
    end
  end

  // A request while idle makes this tick the START tick
  assign take         = (phase_r == PH_IDLE) && tick.req_valid;
  assign cur          = take ? PH_START : phase_r;
  assign is_write_nxt = take ? tick.req_type  : is_write_r;
  assign addr_nxt     = take ? tick.req_addr  : addr_r;
  assign wdata_nxt    = take ? tick.req_wdata : wdata_r;

  // Address nibble, MSB first
  assign addr_off = 3'(cur - PH_ADDR0);
  assign nib_sel  = 3'd7 - addr_off;

  // Next phase and tick outputs
  always_comb begin
    phase_nxt       = PH_IDLE;
    rdata_nxt       = take ? 8'h00 : rdata_r;
    res.lad_drive   = 4'h0;
    res.lad_enable  = 1'b0;
    res.lframe_n    = 1'b1;
    res.busy_res    = 1'b1;
    res.frame_done  = 1'b0;
    res.no_response = 1'b0;
    res.read_data   = 8'h00;
    unique case (cur)
      PH_START: begin
        res.lad_drive  = LAD_START;
        res.lad_enable = 1'b1;
        res.lframe_n   = 1'b0;
        phase_nxt      = PH_CTYPE;
      end
      PH_CTYPE: begin
        res.lad_drive  = is_write_nxt ? CT_WRITE : CT_READ;
        res.lad_enable = 1'b1;
        phase_nxt      = PH_ADDR0;
      end
      PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3,
      PH_ADDR4, PH_ADDR5, PH_ADDR6: begin
        res.lad_drive  = addr_nxt[{nib_sel, 2'b00} +: 4];
        res.lad_enable = 1'b1;
        phase_nxt      = lpc_hmc_phase_t'(cur + 5'd1);
      end
      PH_ADDR7: begin
        res.lad_drive  = addr_nxt[3:0];
        res.lad_enable = 1'b1;
        phase_nxt      = is_write_nxt ? PH_WD0 : PH_TAR0;
      end
      PH_WD0: begin
        res.lad_drive  = wdata_nxt[3:0];
        res.lad_enable = 1'b1;
        phase_nxt      = PH_WD1;
      end
      PH_WD1: begin
        res.lad_drive  = wdata_nxt[7:4];
        res.lad_enable = 1'b1;
        phase_nxt      = PH_TAR0;
      end
      PH_TAR0: begin
        phase_nxt = PH_TAR1;
      end
      PH_TAR1: begin
        // sync on the second turnaround tick skips the sync tick
        if (tick.lad_sample == LAD_SYNC) begin
          phase_nxt = is_write_nxt ? PH_HT0 : PH_RD0;
        end else begin
          phase_nxt = PH_SYNC;
        end
      end
      PH_SYNC: begin
        if (tick.lad_sample == LAD_SYNC) begin
          phase_nxt = is_write_nxt ? PH_HT0 : PH_RD0;
        end else begin
          res.frame_done  = 1'b1;
          res.no_response = 1'b1;
          res.read_data   = RD_ERROR;
          phase_nxt       = PH_IDLE;
        end
      end
      PH_RD0: begin
        rdata_nxt = {4'h0, tick.lad_sample};
        phase_nxt = PH_RD1;
      end
      PH_RD1: begin
        rdata_nxt = {tick.lad_sample, rdata_r[3:0]};
        phase_nxt = PH_HT0;
      end
      PH_HT0: begin
        phase_nxt = PH_HT1;
      end
      PH_HT1: begin
        res.lad_drive  = LAD_IDLE;
        res.lad_enable = 1'b1;
        res.frame_done = 1'b1;
        res.read_data  = is_write_nxt ? 8'h00 : rdata_r;
        phase_nxt      = PH_IDLE;
      end
      default: begin
        // idle tick without a request
        res.busy_res = 1'b0;
        phase_nxt    = PH_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/lpc_host_memory_cycle_top.sv
// ----------------------------------------------------------------------------
// LPC host memory cycle - top level
// Stream wrapper around the LPC memory read/write frame sequencer.
// ----------------------------------------------------------------------------
// Each input item is one LPC clock tick and yields exactly one result item.
// The block takes one item per clock cycle, sustained while out_tready is
// high: the item is captured in an input register, the frame sequencer
// computes the tick's bus drive and status in a single pass, and the result
// lands in an output register. The phase advances only as an item moves from
// the input register into the output register, so stalls on either side
// never skip or repeat a tick.
`default_nettype none

module lpc_host_memory_cycle_top (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: req_addr[31:0], req_wdata[39:32], lad_sample[43:40], zero[47:44]
  input  wire  [47:0] in_tdata,
  // in_tuser: req_valid[0], req_type[1]
  input  wire  [1:0]  in_tuser,
  input  wire         in_tvalid,
  output logic        in_tready,
  // out_tdata: lad_drive[3:0], lad_enable[4], lframe_n[5], busy_res[6],
  //            frame_done[7], no_response[8], read_data[16:9], zero[23:17]
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  wire         out_tready
);
  `include "lpc_host_memory_cycle_top_defines.svh"
  import lpc_hmc_pkg::*;

  logic          s1_valid_r;
  lpc_hmc_tick_t s1_tick_r;
  logic          out_valid_r;
  lpc_hmc_res_t  out_res_r;
  lpc_hmc_res_t  core_res;
  logic          adv;
  logic          in_fire;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tick_r.req_valid  <= in_tuser[0];
      s1_tick_r.req_type   <= in_tuser[1];
      s1_tick_r.req_addr   <= in_tdata[31:0];
      s1_tick_r.req_wdata  <= in_tdata[39:32];
      s1_tick_r.lad_sample <= in_tdata[43:40];
    end
  end

  // Frame sequencer
  lpc_hmc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .tick  (s1_tick_r),
    .res   (core_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.read_data, out_res_r.no_response,
                       out_res_r.frame_done, out_res_r.busy_res,
                       out_res_r.lframe_n, out_res_r.lad_enable,
                       out_res_r.lad_drive};

  // Checks
  `LPC_HMC_ASSERT_IMPL(a_start_drives, out_valid_r && !out_res_r.lframe_n,
    out_res_r.lad_enable && out_res_r.busy_res && (out_res_r.lad_drive == LAD_START),
    "START tick without LAD drive")
  `LPC_HMC_ASSERT_IMPL(a_done_busy, out_valid_r && out_res_r.frame_done,
    out_res_r.busy_res, "frame end outside a frame")
  `LPC_HMC_ASSERT_IMPL(a_nores_err, out_valid_r && out_res_r.no_response,
    out_res_r.frame_done && !out_res_r.lad_enable && (out_res_r.read_data == RD_ERROR),
    "no-response without error status")
  `LPC_HMC_ASSERT_IMPL(a_stall_full, !in_tready,
    s1_valid_r && out_valid_r && !out_tready, "input stalled with room downstream")

endmodule

`default_nettype wire
